// ===== rtl/stb_pkg.sv =====
// ----------------------------------------------------------------------------
// stb_pkg: shared types and codes of the sorted key table
// Operation kinds, status codes, default sizes, the front-to-back command and the result item.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int DEF_DEPTH = 256;
	localparam int DEF_KEY_WIDTH = 32;
	localparam int KIND_W = 3;
	localparam int STATUS_W = 3;
	localparam int INDEX_W = 8;
	localparam int FIELD_KEY_W = 32;
	localparam int POS_W = 9;

	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

	// command from front to back
	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [FIELD_KEY_W-1:0] key;
		logic [INDEX_W-1:0]     index;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [POS_W-1:0]       position;
		logic [FIELD_KEY_W-1:0] key_out;
		logic [POS_W-1:0]       count;
	} res_t;

endpackage

// ===== rtl/stb_fifo.sv =====
// ----------------------------------------------------------------------------
// stb_fifo: two-entry command queue
// Decouples the accepting front end from the table engine.
// ----------------------------------------------------------------------------
module stb_fifo import stb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/stb_engine.sv =====
// ----------------------------------------------------------------------------
// stb_engine: table engine
// RAM-based table with a binary search that alternates a search and a probe state,
// an entry-by-entry shift on insert and remove, and a registered result stage.
// ----------------------------------------------------------------------------
module stb_engine import stb_pkg::*; #(
	parameter int DEPTH = DEF_DEPTH,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic descending,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_PROBE = 4'd2;
	localparam logic [3:0] S_UP_RD = 4'd3;
	localparam logic [3:0] S_UP_WR = 4'd4;
	localparam logic [3:0] S_TAKE = 4'd5;
	localparam logic [3:0] S_DN_RD = 4'd6;
	localparam logic [3:0] S_DN_WR = 4'd7;
	localparam logic [3:0] S_RESP = 4'd8;

	logic [3:0] state_q;
	logic [CW-1:0] count_q, lo_q, hi_q, mid, j_q, pos_q;
	logic [KIND_W-1:0] kind_q;
	logic [KEY_WIDTH-1:0] key_q, kout_q, key_m;
	logic [STATUS_W-1:0] st_q;
	logic hit, go_right;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr, take_addr;
	logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;
	logic res_valid_q;
	res_t res_q;
	logic out_free, accept, is_empty, out_of_range;

	assign key_m = KEY_WIDTH'(cmd.key);
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign hit = (ram_rdata == key_q);
	assign go_right = (key_q > ram_rdata) != descending;
	assign out_free = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign is_empty = (count_q == '0);
	assign out_of_range = XW'(cmd.index) >= XW'(count_q);
	assign res_valid = res_valid_q;
	assign res = res_q;

	function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
		logic [POS_W+CW-1:0] w;
		w = {{POS_W{1'b0}}, v};
		return w[POS_W-1:0];
	endfunction

	function automatic logic [FIELD_KEY_W-1:0] to_key(input logic [KEY_WIDTH-1:0] v);
		logic [FIELD_KEY_W+KEY_WIDTH-1:0] w;
		w = {{FIELD_KEY_W{1'b0}}, v};
		return w[FIELD_KEY_W-1:0];
	endfunction

	always_comb begin
		case (cmd.kind)
			KIND_REMOVE: take_addr = AW'(cmd.index);
			KIND_POP_BACK: take_addr = AW'(count_q - CW'(1));
			default: take_addr = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE: ram_raddr = take_addr;
			S_SEARCH: ram_raddr = mid[AW-1:0];
			S_UP_RD: ram_raddr = AW'(j_q - CW'(1));
			S_DN_RD: ram_raddr = AW'(j_q + CW'(1));
			default: ram_raddr = '0;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(j_q);
		ram_wdata = ram_rdata;
		case (state_q)
			S_UP_RD: begin
				if (j_q <= pos_q) begin
					ram_we = 1'b1;
					ram_waddr = AW'(pos_q);
					ram_wdata = key_q;
				end
			end
			S_UP_WR, S_DN_WR: ram_we = 1'b1;
			default: begin
			end
		endcase
	end

	stb_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk),
		.we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= cmd.kind;
					key_q <= key_m;
					kout_q <= '0;
					st_q <= ST_OK;
					lo_q <= '0;
					hi_q <= count_q;
					pos_q <= '0;
					j_q <= CW'(take_addr);
					if (cmd.kind == KIND_INSERT && count_q == CW'(DEPTH)) begin
						st_q <= ST_FULL;
					end else if (cmd.kind inside {KIND_REMOVE, KIND_POP_BACK, KIND_POP_FRONT}
							&& is_empty) begin
						st_q <= ST_EMPTY;
					end else if (cmd.kind == KIND_REMOVE && out_of_range) begin
						st_q <= ST_RANGE;
					end
				end
			end
			S_SEARCH: begin
				if (lo_q >= hi_q) begin
					pos_q <= lo_q;
					j_q <= count_q;
					if (kind_q == KIND_FIND) begin
						st_q <= ST_NOT_FOUND;
					end
				end
			end
			S_PROBE: begin
				if (hit) begin
					pos_q <= mid;
					j_q <= count_q;
				end else if (go_right) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			S_UP_WR: j_q <= j_q - CW'(1);
			S_TAKE: kout_q <= ram_rdata;
			S_DN_WR: j_q <= j_q + CW'(1);
			S_RESP: begin
				if (out_free) begin
					res_q.status <= st_q;
					res_q.position <= (st_q == ST_OK && kind_q inside {KIND_INSERT, KIND_FIND})
						? to_pos(pos_q) : '0;
					res_q.key_out <= to_key(kout_q);
					res_q.count <= to_pos(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.kind)
							KIND_INSERT: begin
								state_q <= (count_q == CW'(DEPTH)) ? S_RESP : S_SEARCH;
							end
							KIND_FIND: state_q <= S_SEARCH;
							KIND_REMOVE: begin
								state_q <= (is_empty || out_of_range) ? S_RESP : S_TAKE;
							end
							KIND_POP_BACK, KIND_POP_FRONT: begin
								state_q <= is_empty ? S_RESP : S_TAKE;
							end
							KIND_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SEARCH: begin
					if (lo_q >= hi_q) begin
						state_q <= (kind_q == KIND_INSERT) ? S_UP_RD : S_RESP;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (hit) begin
						state_q <= (kind_q == KIND_INSERT) ? S_UP_RD : S_RESP;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_UP_RD: begin
					if (j_q > pos_q) begin
						state_q <= S_UP_WR;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end
				end
				S_UP_WR: state_q <= S_UP_RD;
				S_TAKE: begin
					count_q <= count_q - CW'(1);
					state_q <= S_DN_RD;
				end
				S_DN_RD: state_q <= (j_q < count_q) ? S_DN_WR : S_RESP;
				S_DN_WR: state_q <= S_DN_RD;
				S_RESP: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----------------------------------------------------------------------------
// stb_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/sorted_table_bsearch.sv =====
// ----------------------------------------------------------------------------
// sorted_table_bsearch: sorted key table with binary search
// Front end queues commands; the engine searches, shifts and reports.
// ----------------------------------------------------------------------------
// Commands enter through a two-entry queue and are carried out one at a
// time by the engine. Entries live in a RAM with registered read, so every
// probe passes through a search and a probe state, and every entry move
// through a read and a write state. A search makes at most 9 probes on a
// table of 256. An insert shifts the later entries up one at a time, and a
// remove or pop front shifts them down.
// The result register lets the next command start while a result waits.
module sorted_table_bsearch import stb_pkg::*; #(
	parameter int DEPTH = DEF_DEPTH,
	parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // key[31:0], index[39:32]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // position[8:0], key_out[40:9], count[49:41], zero
	output logic [2:0]  m_tuser   // status[2:0]
);
	logic desc_q;
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	res_t res;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {31'd0, desc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			desc_q <= pwdata[0];
		end
	end

	assign in_cmd.kind = s_tuser;
	assign in_cmd.key = s_tdata[31:0];
	assign in_cmd.index = s_tdata[39:32];

	stb_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	stb_engine #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .descending(desc_q),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {6'd0, res.count, res.key_out, res.position};

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:41] <= 9'(DEPTH))
		else $error("count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[49:41] == 9'(DEPTH))
		else $error("full reported below capacity");
endmodule

// ===== verif/tb_sorted_table_bsearch.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_table_bsearch: self-checking bench of the sorted key table
// Drives table operations over the stream port, predicts every reply with a
// local copy of the table, and compares field by field. Both orders are set.
// ----------------------------------------------------------------------------
module tb_sorted_table_bsearch;
	import stb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH = 256;
	localparam int CYCLE_LIMIT = 8000000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;

	sorted_table_bsearch i_dut (.*);

	// local copy of the table
	logic [31:0] tbl_keys [TBL_DEPTH];
	int unsigned tbl_count;
	bit          tbl_desc;

	res_t replies_due [$];
	int   fail_cnt;
	int   send_idle_pct, recv_stall_pct;
	int   cyc;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic bit table_search(logic [31:0] key, output int unsigned pos);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (key == tbl_keys[mid]) begin
				pos = mid;
				return 1;
			end
			if ((key > tbl_keys[mid]) != tbl_desc) lo = mid + 1;
			else hi = mid;
		end
		pos = lo;
		return 0;
	endfunction

	function automatic logic [31:0] table_take(int unsigned idx);
		logic [31:0] k;
		k = tbl_keys[idx];
		for (int unsigned j = idx; j + 1 < tbl_count; j++) tbl_keys[j] = tbl_keys[j + 1];
		tbl_count--;
		return k;
	endfunction

	function automatic res_t table_apply(logic [2:0] kind, logic [31:0] key, logic [7:0] idx);
		res_t r;
		int unsigned pos;
		r = '0;
		case (kind)
			KIND_INSERT: begin
				if (tbl_count >= TBL_DEPTH) r.status = ST_FULL;
				else begin
					void'(table_search(key, pos));
					for (int unsigned j = tbl_count; j > pos; j--) tbl_keys[j] = tbl_keys[j - 1];
					tbl_keys[pos] = key;
					tbl_count++;
					r.position = 9'(pos);
				end
			end
			KIND_FIND: begin
				if (table_search(key, pos)) r.position = 9'(pos);
				else r.status = ST_NOT_FOUND;
			end
			KIND_REMOVE: begin
				if (tbl_count == 0) r.status = ST_EMPTY;
				else if (idx >= tbl_count) r.status = ST_RANGE;
				else r.key_out = table_take(32'(idx));
			end
			KIND_POP_BACK: begin
				if (tbl_count == 0) r.status = ST_EMPTY;
				else begin
					r.key_out = tbl_keys[tbl_count - 1];
					tbl_count--;
				end
			end
			KIND_POP_FRONT: begin
				if (tbl_count == 0) r.status = ST_EMPTY;
				else r.key_out = table_take(0);
			end
			KIND_CLEAR: tbl_count = 0;
			default: ;
		endcase
		r.count = 9'(tbl_count);
		return r;
	endfunction

	// receiver and checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.position = m_tdata[8:0];
			got.key_out = m_tdata[40:9];
			got.count = m_tdata[49:41];
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply %h", $time, got);
				fail_cnt++;
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				if (got.position !== want.position)
					$display("%0t: position expected %0d actual %0d", $time, want.position,
						got.position);
				if (got.key_out !== want.key_out)
					$display("%0t: key_out expected %h actual %h", $time, want.key_out, got.key_out);
				if (got.count !== want.count)
					$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				if (got !== want) fail_cnt++;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic cfg_write(logic [1:0] addr, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= val; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_order(bit desc);
		s_tvalid <= 0;
		wait (replies_due.size() == 0);
		repeat (20) @(negedge clk);
		cfg_write(2'd0, {31'd0, desc});
		tbl_desc = desc;
	endtask

	// sends one operation; has_typed also checks the prediction against a typed value
	task automatic send_op(logic [2:0] kind, logic [31:0] key, logic [7:0] idx,
			bit has_typed = 0, res_t typed = '0);
		res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {idx, key};
		do @(posedge clk); while (!s_tready);
		r = table_apply(kind, key, idx);
		if (has_typed && r !== typed) begin
			$display("%0t: directed row expected %h predicted %h", $time, typed, r);
			fail_cnt++;
		end
		replies_due.push_back(r);
		@(negedge clk);
	endtask

	function automatic res_t mk(logic [2:0] st, logic [8:0] pos, logic [31:0] ko, logic [8:0] cnt);
		res_t r;
		r.status = st; r.position = pos; r.key_out = ko; r.count = cnt;
		return r;
	endfunction

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [7:0]  idx;
		bit          typed;
		res_t        want;
	} row_t;

	task automatic random_op(int fill_bias);
		int sel;
		logic [31:0] key;
		sel = $urandom_range(99);
		key = ($urandom_range(1)) ? $urandom() : $urandom_range(15);
		if (tbl_count > 0 && $urandom_range(2) == 0) key = tbl_keys[$urandom_range(tbl_count - 1)];
		if (sel < fill_bias) send_op(KIND_INSERT, key, 8'($urandom()));
		else if (sel < fill_bias + 20) send_op(KIND_FIND, key, 8'($urandom()));
		else if (sel < fill_bias + 32) send_op(KIND_REMOVE, key,
			8'((tbl_count > 0 && $urandom_range(3) != 0) ? $urandom_range(tbl_count - 1)
				: $urandom()));
		else if (sel < fill_bias + 40) send_op(KIND_POP_BACK, key, 8'($urandom()));
		else if (sel < fill_bias + 48) send_op(KIND_POP_FRONT, key, 8'($urandom()));
		else if (sel < 99) send_op(KIND_FIND, $urandom(), 8'($urandom()));
		else if ($urandom_range(3) == 0) send_op(KIND_CLEAR, key, 8'($urandom()));
		else send_op(3'($urandom_range(7, 6)), key, 8'($urandom()));
	endtask

	initial begin
		row_t rows [$];
		int pct [4][2];
		fail_cnt = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		tbl_count = 0; tbl_desc = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		rows = '{
			'{KIND_POP_BACK, 32'h0, 8'h0, 1, mk(ST_EMPTY, 0, 0, 0)},
			'{KIND_POP_FRONT, 32'h0, 8'h0, 1, mk(ST_EMPTY, 0, 0, 0)},
			'{KIND_REMOVE, 32'h0, 8'hff, 1, mk(ST_EMPTY, 0, 0, 0)},
			'{KIND_FIND, 32'h0, 8'h0, 1, mk(ST_NOT_FOUND, 0, 0, 0)},
			'{KIND_INSERT, 32'hffffffff, 8'h0, 1, mk(ST_OK, 0, 0, 1)},
			'{KIND_INSERT, 32'h0, 8'h0, 1, mk(ST_OK, 0, 0, 2)},
			'{KIND_INSERT, 32'h80000000, 8'h0, 0, '0},
			'{KIND_INSERT, 32'h80000000, 8'h0, 0, '0},
			'{KIND_INSERT, 32'h5, 8'h0, 0, '0},
			'{KIND_FIND, 32'hffffffff, 8'h0, 0, '0},
			'{KIND_FIND, 32'h7, 8'h0, 1, mk(ST_NOT_FOUND, 0, 0, 5)},
			'{KIND_REMOVE, 32'h0, 8'hff, 1, mk(ST_RANGE, 0, 0, 5)},
			'{KIND_REMOVE, 32'h0, 8'h5, 1, mk(ST_RANGE, 0, 0, 5)},
			'{KIND_REMOVE, 32'h0, 8'h1, 0, '0},
			'{3'd6, 32'hffffffff, 8'hff, 1, mk(ST_OK, 0, 0, 4)},
			'{3'd7, 32'h0, 8'h0, 1, mk(ST_OK, 0, 0, 4)},
			'{KIND_POP_BACK, 32'h0, 8'h0, 1, mk(ST_OK, 0, 32'hffffffff, 3)},
			'{KIND_POP_FRONT, 32'h0, 8'h0, 1, mk(ST_OK, 0, 0, 2)},
			'{KIND_CLEAR, 32'h0, 8'h0, 1, mk(ST_OK, 0, 0, 0)}
		};
		foreach (rows[i]) send_op(rows[i].kind, rows[i].key, rows[i].idx, rows[i].typed,
			rows[i].want);

		// fill to capacity, hit the full case, then flip the order with entries held
		for (int i = 0; i < TBL_DEPTH; i++) send_op(KIND_INSERT, $urandom_range(40), 0);
		send_op(KIND_INSERT, 32'h1234, 0, 1, mk(ST_FULL, 0, 0, 256));
		send_op(KIND_REMOVE, 0, 8'hff, 0);
		for (int i = 0; i < 10; i++) send_op(KIND_FIND, $urandom_range(40), 0);
		set_order(1);
		for (int i = 0; i < 10; i++) send_op(KIND_FIND, $urandom_range(40), 0);
		send_op(KIND_INSERT, 32'h20, 0);
		send_op(KIND_CLEAR, 0, 0);

		pct = '{'{0, 0}, '{78, 0}, '{0, 78}, '{24, 24}};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pct[ph][0];
			recv_stall_pct = pct[ph][1];
			set_order(ph % 2 == 0);
			for (int i = 0; i < 350; i++) random_op((i % 120 < 60) ? 70 : 10);
			// hold off until every reply is back
			s_tvalid <= 0;
			wait (replies_due.size() == 0);
			for (int i = 0; i < 40; i++) random_op(30);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		s_tvalid <= 0;
		wait (replies_due.size() == 0);
		repeat (30) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
